/* hdl/forth_data_stack_top_assert.svh */
// assertion macros for the forth data stack checker
// expects clk and rst_n in the scope where the macros are used
`ifndef FORTH_DATA_STACK_TOP_ASSERT_SVH
`define FORTH_DATA_STACK_TOP_ASSERT_SVH

// same-cycle implication
`define FDS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("forth data stack: same-cycle check failed");

// next-cycle implication
`define FDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("forth data stack: next-cycle check failed");

`endif

/* hdl/fds_pkg.sv */
// shared types and codes for the forth data stack
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fds_pkg;

  localparam int ACT_W = 3;
  localparam int ST_W  = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DUP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DROP = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SWAP = 3'd5;
  localparam logic [ACT_W-1:0] ACT_OVER = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic rd1;
    logic rd2;
    logic wr2;
    logic load_out;
  } fds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;
    logic is_swap;
    logic out_free;
  } fds_sts_t;

endpackage

`default_nettype wire

/* hdl/fds_if.sv */
// request and result channel interfaces for the forth data stack
// depends on fds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fds_in_if #(
  parameter int VALUE_WIDTH = 32
);
  import fds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACT_W-1:0]       action;
  logic [VALUE_WIDTH-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

interface fds_out_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int DEPTH_WIDTH = 7
);
  import fds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] read_value;
  logic [ST_W-1:0]        status;
  logic [DEPTH_WIDTH-1:0] depth;

  modport source (output valid, output read_value, output status, output depth, input ready);
  modport sink (input valid, input read_value, input status, input depth, output ready);
endinterface

`default_nettype wire

/* hdl/fds_ctrl.sv */
// sequencing state machine for the forth data stack
// depends on fds_pkg
`timescale 1ns / 1ps
`default_nettype none

module fds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fds_pkg::fds_sts_t sts,
  output fds_pkg::fds_cmd_t cmd
);
  import fds_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = sts.needs_read ? S_RD1 : S_DONE;
      end
      S_RD1: begin
        state_nxt = sts.is_swap ? S_RD2 : S_DONE;
      end
      S_RD2: begin
        state_nxt = S_WR2;
      end
      S_WR2: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.latch_in = (state_r == S_IDLE) && in_valid;
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.rd1      = (state_r == S_RD1);
  assign cmd.rd2      = (state_r == S_RD2);
  assign cmd.wr2      = (state_r == S_WR2);
  assign cmd.load_out = (state_r == S_DONE) && sts.out_free;

endmodule

`default_nettype wire

/* hdl/fds_datapath.sv */
// stack memory, entry count, request latch and result register
// depends on fds_pkg
`timescale 1ns / 1ps
`default_nettype none

module fds_datapath #(
  parameter  int STACK_DEPTH = 64,
  parameter  int VALUE_WIDTH = 32,
  localparam int ADDR_W      = $clog2(STACK_DEPTH),
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fds_pkg::fds_cmd_t        cmd,
  output fds_pkg::fds_sts_t        sts,
  input  logic [fds_pkg::ACT_W-1:0] in_action,
  input  logic [VALUE_WIDTH-1:0]   in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VALUE_WIDTH-1:0]   out_read_value,
  output logic [fds_pkg::ST_W-1:0] out_status,
  output logic [CNT_W-1:0]         out_depth
);
  import fds_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;

  logic [ACT_W-1:0]       act_r;
  logic [VALUE_WIDTH-1:0] pv_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] swap_r, swap_nxt;
  logic [VALUE_WIDTH-1:0] res_val_r, res_val_nxt;
  logic [ST_W-1:0]        res_st_r, res_st_nxt;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_val_r;
  logic [ST_W-1:0]        out_st_r;
  logic [CNT_W-1:0]       out_depth_r;

  logic [CNT_W-1:0]       cnt_m1, cnt_m2;
  logic [ADDR_W-1:0]      addr_new, addr_top, addr_sec;
  logic                   empty, lt2, full;
  logic [ST_W-1:0]        st_chk;

  logic                   we;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - CNT_W'(2);
  assign addr_new = count_r[ADDR_W-1:0];
  assign addr_top = cnt_m1[ADDR_W-1:0];
  assign addr_sec = cnt_m2[ADDR_W-1:0];

  assign empty = (count_r == '0);
  assign lt2   = (count_r < CNT_W'(2));
  assign full  = (count_r == CNT_W'(STACK_DEPTH));

  // underflow wins over overflow
  always_comb begin
    st_chk = ST_OK;
    unique case (act_r)
      ACT_PUSH: begin
        if (full) st_chk = ST_OVER;
      end
      ACT_POP, ACT_PEEK, ACT_DROP: begin
        if (empty) st_chk = ST_UNDER;
      end
      ACT_DUP: begin
        if (empty) st_chk = ST_UNDER;
        else if (full) st_chk = ST_OVER;
      end
      ACT_SWAP: begin
        if (lt2) st_chk = ST_UNDER;
      end
      ACT_OVER: begin
        if (lt2) st_chk = ST_UNDER;
        else if (full) st_chk = ST_OVER;
      end
      default: begin
        st_chk = ST_OK;
      end
    endcase
  end

  assign sts.needs_read = (st_chk == ST_OK) &&
                          (act_r == ACT_POP || act_r == ACT_PEEK || act_r == ACT_DUP ||
                           act_r == ACT_SWAP || act_r == ACT_OVER);
  assign sts.is_swap    = (act_r == ACT_SWAP);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    count_nxt   = count_r;
    swap_nxt    = swap_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    we          = 1'b0;
    waddr       = addr_new;
    wdata       = pv_r;
    raddr       = addr_top;

    if (cmd.exec) begin
      res_st_nxt  = st_chk;
      res_val_nxt = '0;
      if (st_chk == ST_OK) begin
        unique case (act_r)
          ACT_PUSH: begin
            we        = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          ACT_DROP: begin
            count_nxt = cnt_m1;
          end
          ACT_OVER: begin
            raddr = addr_sec;
          end
          default: begin
            raddr = addr_top;
          end
        endcase
      end
    end

    if (cmd.rd1) begin
      unique case (act_r)
        ACT_POP: begin
          res_val_nxt = rd_data_r;
          count_nxt   = cnt_m1;
        end
        ACT_PEEK: begin
          res_val_nxt = rd_data_r;
        end
        ACT_DUP, ACT_OVER: begin
          res_val_nxt = rd_data_r;
          we          = 1'b1;
          waddr       = addr_new;
          wdata       = rd_data_r;
          count_nxt   = count_r + CNT_W'(1);
        end
        ACT_SWAP: begin
          swap_nxt = rd_data_r;
          raddr    = addr_sec;
        end
        default: begin
          res_val_nxt = res_val_r;
        end
      endcase
    end

    // swap: second entry goes on top, then old top goes below
    if (cmd.rd2) begin
      we    = 1'b1;
      waddr = addr_top;
      wdata = rd_data_r;
    end

    if (cmd.wr2) begin
      we    = 1'b1;
      waddr = addr_sec;
      wdata = swap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r <= in_action;
      pv_r  <= in_push_value;
    end
    swap_r    <= swap_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    if (cmd.load_out) begin
      out_val_r   <= res_val_r;
      out_st_r    <= res_st_r;
      out_depth_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_status     = out_st_r;
  assign out_depth      = out_depth_r;

endmodule

`default_nettype wire

/* hdl/forth_data_stack_top.sv */
// forth data stack top level: push, pop, peek, dup, drop, swap, over
// depends on fds_pkg, fds_if, fds_ctrl and fds_datapath
//
// in_ch carries one request: action code and push value. out_ch returns one
// result per request: read value, status (ok, underflow, overflow) and the
// depth after the action. Both channels use valid/ready; a transfer happens
// on a rising edge with valid and ready high.
// One request is worked on at a time. After acceptance the controller runs
// EXEC, DONE for push, drop, failed and unused actions; EXEC, RD1, DONE for
// pop, peek, dup and over; EXEC, RD1, RD2, WR2, DONE for swap. The result is
// registered as DONE is left and the controller returns to idle to take a
// new request. The sequence is set by the stack memory with one registered
// read and one write per cycle: swap reads and rewrites two entries in turn.
// The output register lets a new request be accepted while the previous
// result waits; a stalled receiver holds the next result in the
// controller's final state until the output register frees.
// Synchronous reset empties the stack and drops any pending result; stack
// entries keep whatever they held and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module forth_data_stack_top #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  fds_in_if.sink   in_ch,
  fds_out_if.source out_ch
);
  import fds_pkg::*;

  fds_cmd_t cmd;
  fds_sts_t sts;

  fds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fds_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_ch.action),
    .in_push_value  (in_ch.push_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_value (out_ch.read_value),
    .out_status     (out_ch.status),
    .out_depth      (out_ch.depth)
  );

endmodule

`default_nettype wire

/* hdl/fds_checker.sv */
// port-level checks for the forth data stack and the bind that attaches them
// depends on fds_pkg and forth_data_stack_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "forth_data_stack_top_assert.svh"

module fds_checker #(
  parameter  int STACK_DEPTH = 64,
  parameter  int VALUE_WIDTH = 32,
  localparam int DW          = $clog2(STACK_DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [VALUE_WIDTH-1:0]   out_read_value,
  input logic [fds_pkg::ST_W-1:0] out_status,
  input logic [DW-1:0]            out_depth
);
  import fds_pkg::*;

  // one request at a time
  `FDS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  `FDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_depth))

  // failed actions return no value
  `FDS_ASSERT_SAME(a_fail_zero, out_valid && out_status != ST_OK, out_read_value == '0)

  `FDS_ASSERT_SAME(a_overflow_full, out_valid && out_status == ST_OVER, out_depth == DW'(STACK_DEPTH))

endmodule

bind forth_data_stack_top fds_checker #(
  .STACK_DEPTH (STACK_DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_fds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_status     (out_ch.status),
  .out_depth      (out_ch.depth)
);

`default_nettype wire
